>>> hw/rtl/wilder_rsi_core_assert.svh
// Assertion macros shared by the wilder_rsi_core RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef WILDER_RSI_CORE_ASSERT_SVH
`define WILDER_RSI_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WRSI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wrsi assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WRSI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wrsi assertion failed");

`endif

>>> hw/rtl/wrsi_pkg.sv
// Package for the Wilder RSI core: widths, constants, microcode ROM and control types.
// No dependencies; used by every other RTL file of the block but the assertion header.
package wrsi_pkg;

    localparam int PRICE_BITS_DEF    = 24;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int ACC_BITS          = 64;   // arithmetic word, wraps modulo 2^64
    localparam int PERIOD_BITS       = 8;
    localparam int RSI_BITS          = 14;
    localparam int DIV_DIGIT_BITS    = 4;    // quotient bits per cycle, narrow mode
    localparam int DIV_CNT_BITS      = $clog2(ACC_BITS + 1);
    localparam int STEP_BITS         = 5;

    localparam logic [RSI_BITS-1:0]    RSI_FULL     = 14'd10000;
    localparam logic [RSI_BITS-1:0]    RSI_NEUTRAL  = 14'd5000;
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 8'd14;
    localparam logic [PERIOD_BITS-1:0] INDEX_MAX    = 8'd255;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ACCUM,
        OP_MUL_GAIN,
        OP_MUL_LOSS,
        OP_ADD_DG,
        OP_ADD_DL,
        OP_DIV_ACC,
        OP_DIV_GAIN,
        OP_DIV_LOSS,
        OP_WB_GAIN,
        OP_WB_LOSS,
        OP_DEN,
        OP_MUL_RSI,
        OP_DIV_RSI,
        OP_WB_RSI,
        OP_SET_FULL,
        OP_SET_NEUTRAL,
        OP_EMIT
    } t_op;

    // jump taken when the condition holds, else fall through to the next step
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_DIV_BUSY,
        C_OUT_FULL,
        C_SKIP,
        C_PRIMED,
        C_WARMING,
        C_LOSS_ZERO,
        C_DEN_ZERO
    } t_cond;

    typedef logic [STEP_BITS-1:0] t_step;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_uword;

    typedef struct packed {
        t_op op;
    } t_ctrl;

    typedef struct packed {
        logic in_fire;
        logic div_busy;
        logic out_full;
        logic skip;
        logic primed;
        logic warming;
        logic loss_zero;
        logic den_zero;
    } t_stat;

    localparam t_step S_IDLE       = 5'd0;
    localparam t_step S_DISPATCH   = 5'd1;
    localparam t_step S_CHK_PRIMED = 5'd2;
    localparam t_step S_ACCUM      = 5'd3;
    localparam t_step S_CHK_WARM   = 5'd4;
    localparam t_step S_FORM_G     = 5'd5;
    localparam t_step S_FORM_G_W   = 5'd6;
    localparam t_step S_FORM_G_WB  = 5'd7;
    localparam t_step S_FORM_L     = 5'd8;
    localparam t_step S_FORM_L_W   = 5'd9;
    localparam t_step S_FORM_L_WB  = 5'd10;
    localparam t_step S_SMOOTH     = 5'd11;
    localparam t_step S_SM_G_ADD   = 5'd12;
    localparam t_step S_SM_G_DIV   = 5'd13;
    localparam t_step S_SM_G_W     = 5'd14;
    localparam t_step S_SM_G_WB    = 5'd15;
    localparam t_step S_SM_L_MUL   = 5'd16;
    localparam t_step S_SM_L_ADD   = 5'd17;
    localparam t_step S_SM_L_DIV   = 5'd18;
    localparam t_step S_SM_L_W     = 5'd19;
    localparam t_step S_SM_L_WB    = 5'd20;
    localparam t_step S_RATIO      = 5'd21;
    localparam t_step S_RSI_MUL    = 5'd22;
    localparam t_step S_RSI_DIV    = 5'd23;
    localparam t_step S_RSI_W      = 5'd24;
    localparam t_step S_RSI_WB     = 5'd25;
    localparam t_step S_FULL       = 5'd26;
    localparam t_step S_NEUTRAL    = 5'd27;
    localparam t_step S_EMIT       = 5'd28;
    localparam t_step S_DONE       = 5'd29;

    function automatic t_uword ucode(input t_step s);
        t_uword w;
        unique case (s)
            S_IDLE:       w = '{op: OP_LOAD,        cond: C_NO_INPUT,  target: S_IDLE};
            S_DISPATCH:   w = '{op: OP_NONE,        cond: C_SKIP,      target: S_NEUTRAL};
            S_CHK_PRIMED: w = '{op: OP_NONE,        cond: C_PRIMED,    target: S_SMOOTH};
            S_ACCUM:      w = '{op: OP_ACCUM,       cond: C_NEVER,     target: S_IDLE};
            S_CHK_WARM:   w = '{op: OP_NONE,        cond: C_WARMING,   target: S_NEUTRAL};
            S_FORM_G:     w = '{op: OP_DIV_GAIN,    cond: C_NEVER,     target: S_IDLE};
            S_FORM_G_W:   w = '{op: OP_NONE,        cond: C_DIV_BUSY,  target: S_FORM_G_W};
            S_FORM_G_WB:  w = '{op: OP_WB_GAIN,     cond: C_NEVER,     target: S_IDLE};
            S_FORM_L:     w = '{op: OP_DIV_LOSS,    cond: C_NEVER,     target: S_IDLE};
            S_FORM_L_W:   w = '{op: OP_NONE,        cond: C_DIV_BUSY,  target: S_FORM_L_W};
            S_FORM_L_WB:  w = '{op: OP_WB_LOSS,     cond: C_ALWAYS,    target: S_RATIO};
            S_SMOOTH:     w = '{op: OP_MUL_GAIN,    cond: C_NEVER,     target: S_IDLE};
            S_SM_G_ADD:   w = '{op: OP_ADD_DG,      cond: C_NEVER,     target: S_IDLE};
            S_SM_G_DIV:   w = '{op: OP_DIV_ACC,     cond: C_NEVER,     target: S_IDLE};
            S_SM_G_W:     w = '{op: OP_NONE,        cond: C_DIV_BUSY,  target: S_SM_G_W};
            S_SM_G_WB:    w = '{op: OP_WB_GAIN,     cond: C_NEVER,     target: S_IDLE};
            S_SM_L_MUL:   w = '{op: OP_MUL_LOSS,    cond: C_NEVER,     target: S_IDLE};
            S_SM_L_ADD:   w = '{op: OP_ADD_DL,      cond: C_NEVER,     target: S_IDLE};
            S_SM_L_DIV:   w = '{op: OP_DIV_ACC,     cond: C_NEVER,     target: S_IDLE};
            S_SM_L_W:     w = '{op: OP_NONE,        cond: C_DIV_BUSY,  target: S_SM_L_W};
            S_SM_L_WB:    w = '{op: OP_WB_LOSS,     cond: C_NEVER,     target: S_IDLE};
            S_RATIO:      w = '{op: OP_DEN,         cond: C_LOSS_ZERO, target: S_FULL};
            S_RSI_MUL:    w = '{op: OP_MUL_RSI,     cond: C_DEN_ZERO,  target: S_FULL};
            S_RSI_DIV:    w = '{op: OP_DIV_RSI,     cond: C_NEVER,     target: S_IDLE};
            S_RSI_W:      w = '{op: OP_NONE,        cond: C_DIV_BUSY,  target: S_RSI_W};
            S_RSI_WB:     w = '{op: OP_WB_RSI,      cond: C_ALWAYS,    target: S_EMIT};
            S_FULL:       w = '{op: OP_SET_FULL,    cond: C_ALWAYS,    target: S_EMIT};
            S_NEUTRAL:    w = '{op: OP_SET_NEUTRAL, cond: C_NEVER,     target: S_IDLE};
            S_EMIT:       w = '{op: OP_EMIT,        cond: C_OUT_FULL,  target: S_EMIT};
            S_DONE:       w = '{op: OP_NONE,        cond: C_ALWAYS,    target: S_IDLE};
            default:      w = '{op: OP_NONE,        cond: C_ALWAYS,    target: S_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/wrsi_if.sv
// Valid/ready channel interfaces for the Wilder RSI core: price input and RSI output.
// Depends on wrsi_pkg.
interface wrsi_in_if #(
    parameter int PRICE_BITS = wrsi_pkg::PRICE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [PRICE_BITS-1:0] close_price;
    logic                  series_start;

    modport source (output valid, close_price, series_start, input ready);
    modport sink   (input valid, close_price, series_start, output ready);
endinterface

interface wrsi_out_if;
    logic                          valid;
    logic                          ready;
    logic [wrsi_pkg::RSI_BITS-1:0] rsi_value;
    logic                          rsi_valid;

    modport source (output valid, rsi_value, rsi_valid, input ready);
    modport sink   (input valid, rsi_value, rsi_valid, output ready);
endinterface

>>> hw/rtl/wilder_rsi_core.sv
// Wilder RSI core: closing price in, one RSI word out per price word.
// Input channel i_in carries close_price (hundredths) and series_start; output
// channel o_out carries rsi_value (hundredths of a percent) and rsi_valid.
// Both are valid/ready; a word moves when valid and ready are high at a clock edge.
// period is written through i_cfg_we / i_cfg_wdata only while no word is in flight;
// the user must keep to this, the core does not enforce it. One word is processed
// at a time by a microcoded sequencer driving the datapath. With period 0, at the
// first sample of a series and while warming up the word gives a neutral result;
// otherwise the plain means are formed or the averages are smoothed, and the ratio
// division follows unless the average loss is zero. The shared divider takes 4
// quotient bits a cycle over the 64-bit word for a division by period and 14 bits
// for the ratio; if gain + loss overflows 64 bits the ratio runs over the full word.
// The result sits in an output register, so the next word is accepted while the
// previous result waits; the core stalls only when a new result is ready and
// the old one has not been taken.
// Reset (synchronous, active low) sets period to 14, clears the series state and
// empties the output register; the first word after reset starts a series.
module wilder_rsi_core #(
    parameter int PRICE_BITS    = wrsi_pkg::PRICE_BITS_DEF,
    parameter int FRACTION_BITS = wrsi_pkg::FRACTION_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [wrsi_pkg::PERIOD_BITS-1:0] i_cfg_wdata,
    wrsi_in_if.sink                          i_in,
    wrsi_out_if.source                       o_out
);
    wrsi_pkg::t_ctrl w_ctrl;
    wrsi_pkg::t_stat w_stat;

    wrsi_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctrl  (w_ctrl)
    );

    wrsi_dp #(
        .PRICE_BITS    (PRICE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_ctrl      (w_ctrl),
        .o_stat      (w_stat),
        .i_in        (i_in),
        .o_out       (o_out)
    );

endmodule

>>> hw/rtl/wrsi_div.sv
// Shared restoring divider: 4 quotient bits per cycle for 8-bit divisors (period),
// 1 bit per cycle for full-width divisors. Depends on wrsi_pkg.
module wrsi_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_narrow,
    input  logic                          i_fast,
    input  logic [wrsi_pkg::ACC_BITS-1:0] i_num,
    input  logic [wrsi_pkg::ACC_BITS-1:0] i_den,
    output logic                          o_busy,
    output logic [wrsi_pkg::ACC_BITS-1:0] o_quo
);
    localparam int AB = wrsi_pkg::ACC_BITS;
    localparam int PB = wrsi_pkg::PERIOD_BITS;
    localparam int DD = wrsi_pkg::DIV_DIGIT_BITS;
    localparam int CB = wrsi_pkg::DIV_CNT_BITS;
    localparam int RB = wrsi_pkg::RSI_BITS;

    logic          r_busy;
    logic [CB-1:0] r_cnt;
    logic          r_narrow;
    logic [AB-1:0] r_num;
    logic [AB-1:0] r_rem;
    logic [AB-1:0] r_den;

    logic [PB-1:0] w_rem_n;
    logic [AB-1:0] w_num_n;
    logic [AB:0]   w_t;
    logic          w_ge;
    logic [AB-1:0] w_rem_w;

    // narrow mode: remainder stays below the 8-bit divisor
    always_comb begin
        logic [PB:0] v_t;
        logic        v_ge;
        w_rem_n = r_rem[PB-1:0];
        w_num_n = r_num;
        for (int k = 0; k < DD; k++) begin
            v_t     = {w_rem_n, w_num_n[AB-1]};
            v_ge    = v_t >= {1'b0, r_den[PB-1:0]};
            w_rem_n = v_ge ? PB'(v_t - {1'b0, r_den[PB-1:0]}) : v_t[PB-1:0];
            w_num_n = {w_num_n[AB-2:0], v_ge};
        end
    end

    assign w_t     = {r_rem, r_num[AB-1]};
    assign w_ge    = w_t >= {1'b0, r_den};
    assign w_rem_w = w_ge ? AB'(w_t - {1'b0, r_den}) : w_t[AB-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            if (i_narrow) begin
                r_cnt <= CB'(AB / DD);
            end else if (i_fast) begin
                r_cnt <= CB'(RB);
            end else begin
                r_cnt <= CB'(AB);
            end
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CB'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_narrow <= i_narrow;
            r_den    <= i_den;
            // fast path: quotient known to fit RSI_BITS, skip the leading bits
            if (!i_narrow && i_fast) begin
                r_rem <= i_num >> RB;
                r_num <= i_num << (AB - RB);
            end else begin
                r_rem <= '0;
                r_num <= i_num;
            end
        end else if (r_busy) begin
            if (r_narrow) begin
                r_rem <= AB'(w_rem_n);
                r_num <= w_num_n;
            end else begin
                r_rem <= w_rem_w;
                r_num <= {r_num[AB-2:0], w_ge};
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_num;

endmodule

>>> hw/rtl/wrsi_seq.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on wrsi_pkg.
module wrsi_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  wrsi_pkg::t_stat i_stat,
    output wrsi_pkg::t_ctrl o_ctrl
);
    wrsi_pkg::t_step  r_step;
    wrsi_pkg::t_step  n_step;
    wrsi_pkg::t_uword w_word;
    logic             w_jump;

    assign w_word = wrsi_pkg::ucode(r_step);

    always_comb begin
        unique case (w_word.cond)
            wrsi_pkg::C_NEVER:     w_jump = 1'b0;
            wrsi_pkg::C_ALWAYS:    w_jump = 1'b1;
            wrsi_pkg::C_NO_INPUT:  w_jump = !i_stat.in_fire;
            wrsi_pkg::C_DIV_BUSY:  w_jump = i_stat.div_busy;
            wrsi_pkg::C_OUT_FULL:  w_jump = i_stat.out_full;
            wrsi_pkg::C_SKIP:      w_jump = i_stat.skip;
            wrsi_pkg::C_PRIMED:    w_jump = i_stat.primed;
            wrsi_pkg::C_WARMING:   w_jump = i_stat.warming;
            wrsi_pkg::C_LOSS_ZERO: w_jump = i_stat.loss_zero;
            wrsi_pkg::C_DEN_ZERO:  w_jump = i_stat.den_zero;
            default:               w_jump = 1'b0;
        endcase
        n_step = w_jump ? w_word.target : wrsi_pkg::t_step'(r_step + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= wrsi_pkg::S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl.op = w_word.op;

endmodule

>>> hw/rtl/wrsi_dp.sv
// Datapath: RSI state, shared multiplier, divider instance, output register.
// Depends on wrsi_pkg, wrsi_if, wrsi_div and wilder_rsi_core_assert.svh.
`include "wilder_rsi_core_assert.svh"

module wrsi_dp #(
    parameter int PRICE_BITS    = wrsi_pkg::PRICE_BITS_DEF,
    parameter int FRACTION_BITS = wrsi_pkg::FRACTION_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [wrsi_pkg::PERIOD_BITS-1:0] i_cfg_wdata,
    input  wrsi_pkg::t_ctrl                  i_ctrl,
    output wrsi_pkg::t_stat                  o_stat,
    wrsi_in_if.sink                          i_in,
    wrsi_out_if.source                       o_out
);
    localparam int AB = wrsi_pkg::ACC_BITS;
    localparam int PB = wrsi_pkg::PERIOD_BITS;
    localparam int RB = wrsi_pkg::RSI_BITS;

    // series state
    logic [PB-1:0]         r_period;
    logic [PRICE_BITS-1:0] r_last;
    logic [PB-1:0]         r_index;
    logic [AB-1:0]         r_gain;
    logic [AB-1:0]         r_loss;
    logic                  r_primed;

    // per-item working registers
    logic [PRICE_BITS-1:0] r_price;
    logic [PB-1:0]         r_idx;
    logic [PRICE_BITS-1:0] r_dg;
    logic [PRICE_BITS-1:0] r_dl;
    logic [AB-1:0]         r_acc;
    logic [AB-1:0]         r_den;
    logic [RB-1:0]         r_value;
    logic                  r_valid;

    logic                  r_out_valid;
    logic [RB-1:0]         r_out_value;
    logic                  r_out_flag;

    logic                  w_in_fire;
    logic                  w_out_free;
    logic                  w_emit;
    logic                  w_gt;
    logic [PB-1:0]         w_idx_next;
    logic [AB-1:0]         w_mul_a;
    logic [RB-1:0]         w_mul_b;
    logic [AB+RB-1:0]      w_prod;
    logic                  w_div_start;
    logic                  w_div_narrow;
    logic [AB-1:0]         w_div_num;
    logic [AB-1:0]         w_div_den;
    logic                  w_div_busy;
    logic [AB-1:0]         w_quo;

    assign i_in.ready = i_rst_n && (i_ctrl.op == wrsi_pkg::OP_LOAD);
    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_emit     = (i_ctrl.op == wrsi_pkg::OP_EMIT) && w_out_free;
    assign w_gt       = i_in.close_price > r_last;
    assign w_idx_next = (r_idx == wrsi_pkg::INDEX_MAX) ? wrsi_pkg::INDEX_MAX : r_idx + 1'b1;

    // one shared multiplier: average * (period - 1), or loss * 10000
    assign w_mul_a = (i_ctrl.op == wrsi_pkg::OP_MUL_GAIN) ? r_gain : r_loss;
    assign w_mul_b = (i_ctrl.op == wrsi_pkg::OP_MUL_RSI) ? wrsi_pkg::RSI_FULL
                                                          : RB'(r_period - 1'b1);
    assign w_prod  = w_mul_a * w_mul_b;

    assign w_div_start  = (i_ctrl.op == wrsi_pkg::OP_DIV_ACC)  ||
                          (i_ctrl.op == wrsi_pkg::OP_DIV_GAIN) ||
                          (i_ctrl.op == wrsi_pkg::OP_DIV_LOSS) ||
                          (i_ctrl.op == wrsi_pkg::OP_DIV_RSI);
    assign w_div_narrow = (i_ctrl.op != wrsi_pkg::OP_DIV_RSI);
    assign w_div_den    = w_div_narrow ? AB'(r_period) : r_den;

    always_comb begin
        unique case (i_ctrl.op)
            wrsi_pkg::OP_DIV_GAIN: w_div_num = r_gain << FRACTION_BITS;
            wrsi_pkg::OP_DIV_LOSS: w_div_num = r_loss << FRACTION_BITS;
            default:               w_div_num = r_acc;
        endcase
    end

    wrsi_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_div_start),
        .i_narrow (w_div_narrow),
        .i_fast   (r_den >= r_loss),
        .i_num    (w_div_num),
        .i_den    (w_div_den),
        .o_busy   (w_div_busy),
        .o_quo    (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= wrsi_pkg::PERIOD_RESET;
            r_last      <= '0;
            r_index     <= '0;
            r_gain      <= '0;
            r_loss      <= '0;
            r_primed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
                r_last      <= r_price;
                r_index     <= w_idx_next;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_ctrl.op)
                wrsi_pkg::OP_LOAD: begin
                    if (w_in_fire && i_in.series_start) begin
                        r_gain   <= '0;
                        r_loss   <= '0;
                        r_primed <= 1'b0;
                    end
                end
                wrsi_pkg::OP_ACCUM: begin
                    r_gain <= r_gain + AB'(r_dg);
                    r_loss <= r_loss + AB'(r_dl);
                end
                wrsi_pkg::OP_WB_GAIN: begin
                    r_gain <= w_quo;
                end
                wrsi_pkg::OP_WB_LOSS: begin
                    r_loss   <= w_quo;
                    r_primed <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_price <= i_in.close_price;
            r_idx   <= i_in.series_start ? '0 : r_index;
            r_dg    <= w_gt ? PRICE_BITS'(i_in.close_price - r_last) : '0;
            r_dl    <= w_gt ? '0 : PRICE_BITS'(r_last - i_in.close_price);
        end
        unique case (i_ctrl.op)
            wrsi_pkg::OP_MUL_GAIN,
            wrsi_pkg::OP_MUL_LOSS,
            wrsi_pkg::OP_MUL_RSI: begin
                r_acc <= w_prod[AB-1:0];
            end
            wrsi_pkg::OP_ADD_DG: begin
                r_acc <= r_acc + (AB'(r_dg) << FRACTION_BITS);
            end
            wrsi_pkg::OP_ADD_DL: begin
                r_acc <= r_acc + (AB'(r_dl) << FRACTION_BITS);
            end
            wrsi_pkg::OP_DEN: begin
                r_den <= r_gain + r_loss;
            end
            wrsi_pkg::OP_WB_RSI: begin
                r_value <= wrsi_pkg::RSI_FULL - w_quo[RB-1:0];
                r_valid <= 1'b1;
            end
            wrsi_pkg::OP_SET_FULL: begin
                r_value <= wrsi_pkg::RSI_FULL;
                r_valid <= 1'b1;
            end
            wrsi_pkg::OP_SET_NEUTRAL: begin
                r_value <= wrsi_pkg::RSI_NEUTRAL;
                r_valid <= 1'b0;
            end
            default: begin
            end
        endcase
        if (w_emit) begin
            r_out_value <= r_value;
            r_out_flag  <= r_valid;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.rsi_value = r_out_value;
    assign o_out.rsi_valid = r_out_flag;

    assign o_stat.in_fire   = w_in_fire;
    assign o_stat.div_busy  = w_div_busy;
    assign o_stat.out_full  = !w_out_free;
    assign o_stat.skip      = (r_period == '0) || (r_idx == '0);
    assign o_stat.primed    = r_primed;
    assign o_stat.warming   = r_idx < r_period;
    assign o_stat.loss_zero = (r_loss == '0);
    assign o_stat.den_zero  = (r_den == '0);

    `WRSI_ASSERT_IMP(a_div_start_idle, i_clk, i_rst_n, w_div_start, !w_div_busy)
    `WRSI_ASSERT_IMP(a_valid_needs_primed, i_clk, i_rst_n, w_emit && r_valid, r_primed)
    `WRSI_ASSERT_IMP(a_neutral_when_invalid, i_clk, i_rst_n, r_out_valid && !r_out_flag, r_out_value == wrsi_pkg::RSI_NEUTRAL)
    `WRSI_ASSERT_NXT(a_emit_advances_index, i_clk, i_rst_n, w_emit, r_index != '0)

endmodule

>>> tb/tb_wilder_rsi_core.sv
// Self-checking testbench for wilder_rsi_core: directed and random price streams,
// predicted RSI words checked in order. Depends on wrsi_pkg, wrsi_if.sv and the core RTL.
`timescale 1ns / 1ps

module tb_wilder_rsi_core;

    localparam int PRICE_W = wrsi_pkg::PRICE_BITS_DEF;
    localparam int FRAC_W  = wrsi_pkg::FRACTION_BITS_DEF;
    localparam int RSI_W   = wrsi_pkg::RSI_BITS;
    localparam int PER_W   = wrsi_pkg::PERIOD_BITS;
    localparam logic [PRICE_W-1:0] PRICE_TOP = {PRICE_W{1'b1}};

    typedef struct packed {
        logic [RSI_W-1:0] value;
        logic             flag;
    } t_rsi_word;

    // Tracks series state and holds the RSI words still owed by the core.
    class rsi_tracker;
        logic [PER_W-1:0]   period;
        logic [PRICE_W-1:0] last_close;
        logic [63:0]        gain_avg;
        logic [63:0]        loss_avg;
        logic [PER_W-1:0]   sample_index;
        bit                 primed;
        t_rsi_word          pending_rsi[$];
        int                 n_fail;
        int                 n_results;
        int                 n_computed;

        function new();
            period       = wrsi_pkg::PERIOD_RESET;
            last_close   = '0;
            gain_avg     = '0;
            loss_avg     = '0;
            sample_index = '0;
            primed       = 1'b0;
            n_fail       = 0;
            n_results    = 0;
            n_computed   = 0;
        endfunction

        function logic [RSI_W-1:0] rsi_from_averages(logic [63:0] g, logic [63:0] l);
            logic [63:0] den;
            logic [63:0] v;
            if (l == 64'd0)
                return wrsi_pkg::RSI_FULL;
            den = g + l;
            if (den == 64'd0)
                return wrsi_pkg::RSI_FULL;
            v = 64'(wrsi_pkg::RSI_FULL) - (64'(wrsi_pkg::RSI_FULL) * l) / den;
            return v[RSI_W-1:0];
        endfunction

        function void note_price(logic [PRICE_W-1:0] price, logic start);
            logic [PER_W-1:0] idx;
            logic [63:0]      g;
            logic [63:0]      l;
            logic [63:0]      p64;
            t_rsi_word        r;
            idx     = start ? '0 : sample_index;
            r.value = wrsi_pkg::RSI_NEUTRAL;
            r.flag  = 1'b0;
            p64     = 64'(period);
            if (start) begin
                gain_avg = '0;
                loss_avg = '0;
                primed   = 1'b0;
            end
            if (period != '0 && idx != '0) begin
                g = '0;
                l = '0;
                if (price > last_close)
                    g = 64'(price) - 64'(last_close);
                else
                    l = 64'(last_close) - 64'(price);
                if (primed) begin
                    gain_avg = (gain_avg * (p64 - 64'd1) + (g << FRAC_W)) / p64;
                    loss_avg = (loss_avg * (p64 - 64'd1) + (l << FRAC_W)) / p64;
                    r.value  = rsi_from_averages(gain_avg, loss_avg);
                    r.flag   = 1'b1;
                end else begin
                    gain_avg = gain_avg + g;
                    loss_avg = loss_avg + l;
                    // plain means; also covers a period lowered below the index
                    if (idx >= period) begin
                        gain_avg = (gain_avg << FRAC_W) / p64;
                        loss_avg = (loss_avg << FRAC_W) / p64;
                        primed   = 1'b1;
                        r.value  = rsi_from_averages(gain_avg, loss_avg);
                        r.flag   = 1'b1;
                    end
                end
            end
            last_close   = price;
            sample_index = (idx < wrsi_pkg::INDEX_MAX) ? idx + 8'd1 : wrsi_pkg::INDEX_MAX;
            pending_rsi  = {pending_rsi, r};
        endfunction

        function void check_rsi(logic [RSI_W-1:0] value, logic flag);
            t_rsi_word want;
            if (pending_rsi.size() == 0) begin
                $error("unexpected RSI word: rsi_value %0d rsi_valid %0d", value, flag);
                n_fail++;
                return;
            end
            want = pending_rsi.pop_front();
            n_results++;
            if (want.flag)
                n_computed++;
            if (value !== want.value) begin
                $error("rsi_value mismatch: expected %0d, actual %0d", want.value, value);
                n_fail++;
            end
            if (flag !== want.flag) begin
                $error("rsi_valid mismatch: expected %0d, actual %0d", want.flag, flag);
                n_fail++;
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [PER_W-1:0] i_cfg_wdata;

    wrsi_in_if #(.PRICE_BITS(PRICE_W)) in_ch();
    wrsi_out_if                        out_ch();

    wilder_rsi_core #(
        .PRICE_BITS    (PRICE_W),
        .FRACTION_BITS (FRAC_W)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    rsi_tracker   sb = new();
    int           send_idle;
    int           recv_idle;
    int           words_sent;
    logic [PRICE_W-1:0] walk_price;

    int phase_period[8] = '{255, 14, 1, 7, 0, 3, 2, 0};
    int phase_len[8]    = '{320, 230, 150, 180, 60, 120, 90, 150};

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic void pick_idling();
        if (words_sent < 433) begin
            send_idle = 18;
            recv_idle = 60;
        end else if (words_sent < 866) begin
            send_idle = 60;
            recv_idle = 18;
        end else begin
            send_idle = 0;
            recv_idle = 0;
        end
    endfunction

    function automatic logic [PRICE_W-1:0] next_walk_price();
        int unsigned r;
        longint      p;
        longint      delta;
        r = $urandom_range(99);
        p = longint'(walk_price);
        if (r < 8) begin
            p = longint'($urandom_range(0, int'(PRICE_TOP)));
        end else if (r >= 14) begin
            delta = longint'($urandom_range(0, 3000));
            p = $urandom_range(1) ? p + delta : p - delta;
            if (p < 0)
                p = 0;
            if (p > longint'(PRICE_TOP))
                p = longint'(PRICE_TOP);
        end
        walk_price = p[PRICE_W-1:0];
        return walk_price;
    endfunction

    task automatic send_price(input logic [PRICE_W-1:0] price, input logic start);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.close_price  <= price;
        in_ch.series_start <= start;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        sb.note_price(price, start);
        words_sent++;
        pick_idling();
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.pending_rsi.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_period(input logic [PER_W-1:0] p);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= p;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.period = p;
    endtask

    // result side: random back-pressure, check every accepted word
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && out_ch.valid && out_ch.ready)
                sb.check_rsi(out_ch.rsi_value, out_ch.rsi_valid);
            out_ch.ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    initial begin
        logic start;
        logic [PRICE_W-1:0] price;
        words_sent = 0;
        pick_idling();
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_wdata        <= '0;
        in_ch.valid        <= 1'b0;
        in_ch.close_price  <= '0;
        in_ch.series_start <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first word after reset opens a series even without the flag
        send_price('0, 1'b0);
        send_price(PRICE_TOP, 1'b0);
        send_price('0, 1'b0);
        // period zero: neutral output, state still advances
        set_period(8'd0);
        send_price(24'd5, 1'b1);
        send_price(24'd7, 1'b0);
        send_price(24'd3, 1'b0);
        // index already past the new period, then flat, all-loss and all-gain runs
        set_period(8'd2);
        send_price(24'd10, 1'b0);
        send_price(24'd10, 1'b0);
        send_price(PRICE_TOP, 1'b1);
        send_price('0, 1'b0);
        send_price('0, 1'b0);
        send_price('0, 1'b1);
        send_price(PRICE_TOP, 1'b0);
        send_price(PRICE_TOP, 1'b0);
        // period lowered mid warm-up, then changed once primed
        set_period(8'd20);
        send_price(24'd1000, 1'b1);
        send_price(24'd1100, 1'b0);
        send_price(24'd900, 1'b0);
        send_price(24'd950, 1'b0);
        send_price(24'd1200, 1'b0);
        set_period(8'd3);
        send_price(24'd1000, 1'b0);
        send_price(24'd1010, 1'b0);
        set_period(8'd1);
        send_price(24'd990, 1'b0);
        send_price(24'd1500, 1'b0);

        phase_period[7] = $urandom_range(8, 60);
        for (int ph = 0; ph < 8; ph++) begin
            set_period(phase_period[ph][PER_W-1:0]);
            for (int i = 0; i < phase_len[ph]; i++) begin
                // period 255 runs one long series to push the index into saturation
                start = (i == 0) || (phase_period[ph] != 255 && $urandom_range(59) == 0);
                if (start) begin
                    walk_price = PRICE_W'($urandom_range(0, int'(PRICE_TOP)));
                    price = walk_price;
                end else begin
                    price = next_walk_price();
                end
                send_price(price, start);
            end
        end

        drain();
        repeat (80) @(posedge i_clk);
        $display("Ran %0d price words, checked %0d RSI words (%0d computed, rest neutral),",
                 words_sent, sb.n_results, sb.n_computed);
        $display("periods 0, 1, 2, 3, 7, 14, 20, 255 and one random, under three idling mixes.");
        if (sb.n_fail == 0 && sb.pending_rsi.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
